[rtl/nptc_pkg.sv]
// ----------------------------------------------------------------------------
// nptc_pkg: numeric text nibble codec shared types and constants
// Character codes, escape code and the code to character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package nptc_pkg;

   localparam int ByteWidth   = 8;
   localparam int NibbleWidth = 4;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [NibbleWidth-1:0] nibble_type;

   localparam nibble_type CodeNul   = 4'd0;
   localparam nibble_type CodeDot   = 4'd11;
   localparam nibble_type CodePlus  = 4'd12;
   localparam nibble_type CodeMinus = 4'd13;
   localparam nibble_type CodeEnd   = 4'd14;
   localparam nibble_type CodeEsc   = 4'd15;

   localparam byte_type CharNul   = 8'h00;
   localparam byte_type CharZero  = 8'h30;
   localparam byte_type CharNine  = 8'h39;
   localparam byte_type CharDot   = 8'h2E;
   localparam byte_type CharPlus  = 8'h2B;
   localparam byte_type CharMinus = 8'h2D;

   typedef struct packed {
      byte_type out_byte;
      logic     last;
   } result_type;

   function automatic nibble_type char_to_code(input byte_type c);
      nibble_type code;
      byte_type   diff;
      diff = c - CharZero;
      case (c) inside
         CharNul:              code = CodeNul;
         [CharZero:CharNine]:  code = diff[NibbleWidth-1:0] + 4'd1;
         CharDot:              code = CodeDot;
         CharPlus:             code = CodePlus;
         CharMinus:            code = CodeMinus;
         default:              code = CodeEsc;
      endcase
      return code;
   endfunction

   function automatic byte_type code_to_char(input nibble_type code);
      byte_type c;
      case (code) inside
         [4'd1:4'd10]: c = CharZero + {4'd0, code} - 8'd1;
         CodeDot:      c = CharDot;
         CodePlus:     c = CharPlus;
         CodeMinus:    c = CharMinus;
         default:      c = CharNul;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/nptc_req_if.sv]
// ----------------------------------------------------------------------------
// nptc_req_if: input byte channel
// Valid/ready channel carrying one input byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nptc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/nptc_rsp_if.sv]
// ----------------------------------------------------------------------------
// nptc_rsp_if: result byte channel
// Valid/ready channel carrying one result byte and its last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nptc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/nibble_pack_text_codec_core.sv]
// ----------------------------------------------------------------------------
// nibble_pack_text_codec_core: numeric text nibble codec
// Packs numeric text into 4-bit codes, two per byte, and unpacks them again.
//
// Usage:
//   req_if  - input beats: one character (pack) or one packed byte (unpack).
//   rsp_if  - result beats: out_byte and last; last marks the string end.
//   csr_wr_en/csr_wr_data - selects direction (0 pack, 1 unpack); a write
//             also clears the nibble phase, held code and pending escape.
//             Write only while no results are outstanding.
//   Each input beat yields zero, one or two result beats, held in a
//   two-entry result register. The first result beat is registered and
//   appears in the cycle after its input beat is taken. An input beat
//   producing at most one result is taken every cycle while the receiver
//   is ready; two results leave one by one through the single result port.
//   A new input beat is taken in the cycle the last buffered result leaves.
//   When the receiver stalls, results hold and req_if.ready drops once the
//   buffer is not about to empty. Reset selects pack mode and empties all.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_pack_text_codec_core
   import nptc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nptc_req_if.sink   req_if,
   nptc_rsp_if.source rsp_if,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data
);

   logic         direction_ff;
   logic         high_half_next_ff, high_half_next_in;
   nibble_type   held_low_code_ff,  held_low_code_in;
   logic         raw_byte_next_ff,  raw_byte_next_in;
   logic [1:0]   count_ff,          count_in;
   result_type   res0_ff,           res0_in;
   result_type   res1_ff,           res1_in;

   logic         push;
   logic         pop;
   logic [1:0]   new_count;
   result_type   new_res0;
   result_type   new_res1;
   byte_type     c;
   nibble_type   code;
   nibble_type   lo_nib;
   nibble_type   hi_nib;
   byte_type     packed_byte;

   assign req_if.ready    = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_if.ready);
   assign rsp_if.valid    = (count_ff != 2'd0);
   assign rsp_if.out_byte = res0_ff.out_byte;
   assign rsp_if.last     = res0_ff.last;

   assign push = req_if.valid && req_if.ready;
   assign pop  = rsp_if.valid && rsp_if.ready;

   assign c           = req_if.in_byte;
   assign code        = char_to_code(c);
   assign lo_nib      = c[3:0];
   assign hi_nib      = c[7:4];
   assign packed_byte = high_half_next_ff ? {code, held_low_code_ff} : {4'd0, code};

   always_comb begin
      new_count         = 2'd0;
      new_res0          = '{out_byte: CharNul, last: 1'b0};
      new_res1          = '{out_byte: CharNul, last: 1'b0};
      high_half_next_in = high_half_next_ff;
      held_low_code_in  = held_low_code_ff;
      raw_byte_next_in  = raw_byte_next_ff;
      if (!direction_ff) begin
         if (!high_half_next_ff && code != CodeNul && code != CodeEsc) begin
            held_low_code_in  = code;
            high_half_next_in = 1'b1;
         end else begin
            high_half_next_in = 1'b0;
            held_low_code_in  = CodeNul;
            new_res0.out_byte = packed_byte;
            new_count         = 2'd1;
            if (code == CodeNul) begin
               new_res0.last = 1'b1;
            end else if (code == CodeEsc) begin
               new_res1.out_byte = c;
               new_count         = 2'd2;
            end
         end
      end else begin
         high_half_next_in = 1'b0;
         if (raw_byte_next_ff) begin
            raw_byte_next_in  = 1'b0;
            new_res0.out_byte = c;
            new_count         = 2'd1;
         end else if (lo_nib == CodeNul || lo_nib == CodeEnd) begin
            new_res0.last = 1'b1;
            new_count     = 2'd1;
         end else if (lo_nib == CodeEsc) begin
            raw_byte_next_in = 1'b1;
         end else begin
            new_res0.out_byte = code_to_char(lo_nib);
            if (hi_nib == CodeNul || hi_nib == CodeEnd) begin
               new_res1.last = 1'b1;
               new_count     = 2'd2;
            end else if (hi_nib == CodeEsc) begin
               raw_byte_next_in = 1'b1;
               new_count        = 2'd1;
            end else begin
               new_res1.out_byte = code_to_char(hi_nib);
               new_count         = 2'd2;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      res0_in  = res0_ff;
      res1_in  = res1_ff;
      if (push) begin
         count_in = new_count;
         res0_in  = new_res0;
         res1_in  = new_res1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         res0_in  = res1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff      <= 1'b0;
         high_half_next_ff <= 1'b0;
         held_low_code_ff  <= CodeNul;
         raw_byte_next_ff  <= 1'b0;
         count_ff          <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            direction_ff      <= csr_wr_data;
            high_half_next_ff <= 1'b0;
            held_low_code_ff  <= CodeNul;
            raw_byte_next_ff  <= 1'b0;
         end else if (push) begin
            high_half_next_ff <= high_half_next_in;
            held_low_code_ff  <= held_low_code_in;
            raw_byte_next_ff  <= raw_byte_next_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      res0_ff <= res0_in;
      res1_ff <= res1_in;
   end

endmodule

`default_nettype wire

[dv/nptc_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nptc_tb_pkg: scoreboard for the numeric text nibble codec
// Predicts the result beats of each accepted input beat from its own copy of
// the direction and stream state, and checks arriving results in order.
// ----------------------------------------------------------------------------
package nptc_tb_pkg;
   import nptc_pkg::*;

   class codec_scoreboard;
      bit          unpack_mode;
      bit          high_half;
      nibble_type  held_code;
      bit          raw_next;
      result_type  pending_results[$];
      int unsigned mismatch_count;
      int unsigned checked_count;

      function new();
         unpack_mode    = 1'b0;
         mismatch_count = 0;
         checked_count  = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         high_half = 1'b0;
         held_code = CodeNul;
         raw_next  = 1'b0;
      endfunction

      function void set_direction(bit unpack);
         unpack_mode = unpack;
         clear_stream();
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function nibble_type code_of(byte_type c);
         byte_type offset;
         offset = c - CharZero;
         if (c == CharNul) return CodeNul;
         if (c >= CharZero && c <= CharNine) return nibble_type'(offset + 8'd1);
         if (c == CharDot) return CodeDot;
         if (c == CharPlus) return CodePlus;
         if (c == CharMinus) return CodeMinus;
         return CodeEsc;
      endfunction

      function byte_type char_of(nibble_type n);
         if (n == CodeDot) return CharDot;
         if (n == CodePlus) return CharPlus;
         if (n == CodeMinus) return CharMinus;
         return CharZero + byte_type'(n) - 8'd1;
      endfunction

      function void push_result(byte_type b, bit l);
         result_type r;
         r.out_byte = b;
         r.last     = l;
         pending_results.push_back(r);
      endfunction

      function void predict_beat(byte_type b);
         nibble_type n;
         nibble_type nib;
         byte_type   packed_byte;
         bit         done;
         if (!unpack_mode) begin
            n = code_of(b);
            if (!high_half && n != CodeNul && n != CodeEsc) begin
               held_code = n;
               high_half = 1'b1;
            end else begin
               packed_byte = high_half ? {n, held_code} : {4'd0, n};
               high_half   = 1'b0;
               held_code   = CodeNul;
               if (n == CodeNul) begin
                  push_result(packed_byte, 1'b1);
               end else if (n == CodeEsc) begin
                  push_result(packed_byte, 1'b0);
                  push_result(b, 1'b0);
               end else begin
                  push_result(packed_byte, 1'b0);
               end
            end
         end else begin
            high_half = 1'b0;
            if (raw_next) begin
               raw_next = 1'b0;
               push_result(b, 1'b0);
            end else begin
               done = 1'b0;
               for (int h = 0; h < 2 && !done; h++) begin
                  nib = h ? b[7:4] : b[3:0];
                  if (nib == CodeNul || nib == CodeEnd) begin
                     push_result(CharNul, 1'b1);
                     done = 1'b1;
                  end else if (nib == CodeEsc) begin
                     raw_next = 1'b1;
                     done     = 1'b1;
                  end else begin
                     push_result(char_of(nib), 1'b0);
                  end
               end
            end
         end
      endfunction

      task report_mismatch(string what);
         if (mismatch_count < 30) $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_result(byte_type got_byte, logic got_last);
         result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                      got_byte, got_last));
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         if (got_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, want.out_byte));
         if (got_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                      got_last, want.last, want.out_byte));
      endtask
   endclass

endpackage

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: numeric text nibble codec
// Drives directed and random character and packed byte streams in both
// directions with random gaps and output stalls, and checks every result
// beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;
   import nptc_pkg::*;
   import nptc_tb_pkg::*;

   localparam bit DirPack   = 1'b0;
   localparam bit DirUnpack = 1'b1;

   localparam int IdlePercent     = 26;
   localparam int HoldOffCycles   = 80;
   localparam int WatchdogLimit   = 4000;
   localparam int ItemsPerPhase   = 150;
   localparam int SettleCycles    = 6;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   nptc_req_if req_bus ();
   nptc_rsp_if rsp_bus ();

   codec_scoreboard book;
   bit              calm;
   bit              hold_off_request;
   int unsigned     beats_in;

   nibble_pack_text_codec_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_byte(input byte_type value);
      while (!calm && $urandom_range(99) < IdlePercent) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.predict_beat(value);
      beats_in++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_direction(input bit unpack);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= unpack;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.set_direction(unpack);
   endtask

   function automatic byte_type random_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return CharNul;
      if (pick < 60) return CharZero + byte_type'($urandom_range(9));
      if (pick < 65) return CharDot;
      if (pick < 70) return CharPlus;
      if (pick < 75) return CharMinus;
      return byte_type'($urandom_range(255));
   endfunction

   function automatic nibble_type random_nibble();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 82) return nibble_type'($urandom_range(13, 1));
      if (pick < 90) return pick[0] ? CodeEnd : CodeNul;
      return CodeEsc;
   endfunction

   function automatic byte_type random_packed();
      if ($urandom_range(99) < 10) return byte_type'($urandom_range(255));
      return {random_nibble(), random_nibble()};
   endfunction

   task automatic random_phase(input bit unpack, input bit with_calm, input bit with_hold);
      write_direction(unpack);
      for (int i = 0; i < ItemsPerPhase; i++) begin
         if (with_calm) calm = (i >= 30 && i < 90);
         if (with_hold && i == 20) hold_off_request = 1'b1;
         send_byte(unpack ? random_packed() : random_char());
      end
      calm = 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int unsigned stall_left;
      bit          go;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request && stall_left == 0) begin
            stall_left       = HoldOffCycles;
            hold_off_request = 1'b0;
         end
         if (stall_left != 0) begin
            go = 1'b0;
            stall_left--;
         end else begin
            go = calm || $urandom_range(99) >= IdlePercent;
         end
         rsp_bus.ready <= go;
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            book.check_result(rsp_bus.out_byte, rsp_bus.last);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WatchdogLimit) begin
            $display("testbench: no beat moved for %0d cycles, %0d results outstanding",
                     quiet, book.pending());
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      byte_type pack_cases[$];
      byte_type unpack_cases[$];
      book             = new();
      calm             = 1'b0;
      hold_off_request = 1'b0;
      beats_in         = 0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pack: pairs, terminators in both phases, escapes in both phases
      pack_cases = '{8'h31, 8'h32, CharDot, 8'h35, CharNul,
                     CharPlus, CharMinus, CharNine, CharNul,
                     CharZero, 8'h41, 8'h78, 8'hFF, 8'h80,
                     8'h2F, 8'h3A, CharNul, 8'h37, CharNul};
      write_direction(DirPack);
      foreach (pack_cases[i]) send_byte(pack_cases[i]);

      // unpack: terminator nibbles, escape in either half, raw zero and raw escape
      unpack_cases = '{8'h00, 8'h32, 8'hDC, 8'hBA, 8'h1E, 8'hE1,
                       8'h0F, 8'h00, 8'hF1, 8'hFF, 8'hAF, 8'h0F,
                       8'hFF, 8'h80, 8'h9D, 8'hC7, 8'h10};
      write_direction(DirUnpack);
      foreach (unpack_cases[i]) send_byte(unpack_cases[i]);

      random_phase(DirPack, 1'b1, 1'b0);
      random_phase(DirUnpack, 1'b0, 1'b1);
      random_phase(DirPack, 1'b0, 1'b1);
      random_phase(DirUnpack, 1'b1, 1'b0);

      drain();
      $display("testbench: %0d input beats, %0d result beats checked, %0d mismatches",
               beats_in, book.checked_count, book.mismatch_count);
      $display("testbench: both directions, escapes, terminators and long output stalls");
      if (book.mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/nptc_pkg.sv
rtl/nptc_req_if.sv
rtl/nptc_rsp_if.sv
rtl/nibble_pack_text_codec_core.sv
dv/nptc_tb_pkg.sv
dv/testbench.sv
